// File: rtl/ffd_pkg.sv
// shared types and codes for the frenet frame block
package ffd_pkg;

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } vec_t;

    typedef struct packed {
        vec_t p;
        vec_t v;
        vec_t a;
    } item_t;

    typedef struct packed {
        vec_t       p;
        vec_t       t;
        vec_t       n;
        vec_t       b;
        logic [1:0] status;
    } frame_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FLAT  = 2'd1;
    localparam logic [1:0] ST_NOTAN = 2'd2;

    localparam logic [1:0] KIND_POS = 2'd0;
    localparam logic [1:0] KIND_TAN = 2'd1;
    localparam logic [1:0] KIND_NRM = 2'd2;
    localparam logic [1:0] KIND_BIN = 2'd3;

endpackage

// File: rtl/frenet_frame_from_derivatives.sv
// top level of the frenet frame block
// Each input transaction (position, first and second derivative, signed fixed point with
// FRAC_BITS fraction bits) yields four result transactions in order: position, unit tangent,
// normal and binormal, the last one flagged by is_last, all carrying the same frame_status.
// The back end works one item at a time through a shared 32x32 multiplier, a one-step-per-cycle
// square root and a restoring divider; the vector is normalized twice, the cross product being
// prescaled before its normalization, and a zero tangent or zero curvature skips part of the
// work. A two-entry queue in front and a one-frame output stage let input and output run while
// the back end is busy.
// The dimension register is taken when a transaction is accepted; write it only while idle.
module frenet_frame_from_derivatives #(
    parameter int FRAC_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_wdata,
    input  logic               push,
    output logic               full,
    input  logic signed [31:0] pos_x,
    input  logic signed [31:0] pos_y,
    input  logic signed [31:0] pos_z,
    input  logic signed [31:0] vel_x,
    input  logic signed [31:0] vel_y,
    input  logic signed [31:0] vel_z,
    input  logic signed [31:0] acc_x,
    input  logic signed [31:0] acc_y,
    input  logic signed [31:0] acc_z,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         vector_kind,
    output logic signed [31:0] comp_x,
    output logic signed [31:0] comp_y,
    output logic signed [31:0] comp_z,
    output logic [1:0]         frame_status,
    output logic               is_last
);

    logic            q_valid;
    logic            q_pop;
    ffd_pkg::item_t  q_data;
    logic            frame_valid;
    logic            frame_ready;
    ffd_pkg::frame_t frame;

    ffd_front #(.FRAC_BITS(FRAC_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .push      (push),
        .full      (full),
        .pos_x     (pos_x),
        .pos_y     (pos_y),
        .pos_z     (pos_z),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .vel_z     (vel_z),
        .acc_x     (acc_x),
        .acc_y     (acc_y),
        .acc_z     (acc_z),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop)
    );

    ffd_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_valid     (q_valid),
        .q_data      (q_data),
        .q_pop       (q_pop),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    ffd_emit u_emit (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_valid  (frame_valid),
        .frame_ready  (frame_ready),
        .frame        (frame),
        .empty        (empty),
        .pop          (pop),
        .vector_kind  (vector_kind),
        .comp_x       (comp_x),
        .comp_y       (comp_y),
        .comp_z       (comp_z),
        .frame_status (frame_status),
        .is_last      (is_last)
    );

endmodule

// File: rtl/ffd_front.sv
// front end: dimension register, lift to 3d form and two-entry item queue
module ffd_front #(
    parameter int FRAC_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_wdata,
    input  logic                push,
    output logic                full,
    input  logic signed [31:0]  pos_x,
    input  logic signed [31:0]  pos_y,
    input  logic signed [31:0]  pos_z,
    input  logic signed [31:0]  vel_x,
    input  logic signed [31:0]  vel_y,
    input  logic signed [31:0]  vel_z,
    input  logic signed [31:0]  acc_x,
    input  logic signed [31:0]  acc_y,
    input  logic signed [31:0]  acc_z,
    output logic                q_valid,
    output ffd_pkg::item_t      q_data,
    input  logic                q_pop
);

    localparam logic [1:0] DIM_1D = 2'd1;
    localparam logic [1:0] DIM_2D = 2'd2;
    localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

    logic [1:0]     dim_reg;
    ffd_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    ffd_pkg::item_t lifted;
    logic           do_push;

    always_comb
    begin
        lifted.p = '{x: pos_x, y: pos_y, z: pos_z};
        lifted.v = '{x: vel_x, y: vel_y, z: vel_z};
        lifted.a = '{x: acc_x, y: acc_y, z: acc_z};
        unique case (dim_reg)
            DIM_1D:
            begin
                lifted.p = '{x: '0, y: pos_x, z: '0};
                lifted.v = '{x: ONE, y: vel_x, z: '0};
                lifted.a = '{x: '0, y: acc_x, z: '0};
            end
            DIM_2D:
            begin
                lifted.p.z = '0;
                lifted.v.z = '0;
                lifted.a.z = '0;
            end
            default:
            begin
            end
        endcase
    end

    assign full    = (count_reg == 2'd2);
    assign do_push = push && !full;
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= lifted;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg    <= 2'd3;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                dim_reg <= cfg_wdata;
            end
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop && q_valid)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(do_push) - 2'(q_pop && q_valid);
        end
    end

endmodule

// File: rtl/ffd_back.sv
// back end: sequencer with shared multiplier, square root and divider
module ffd_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  ffd_pkg::item_t  q_data,
    output logic            q_pop,
    output logic            frame_valid,
    input  logic            frame_ready,
    output ffd_pkg::frame_t frame
);

    localparam int QW = FRAC_BITS + 1;
    localparam int BW = $clog2(QW);

    typedef enum logic [12:0] {
        S_IDLE  = 13'b0000000000001,
        S_NZERO = 13'b0000000000010,
        S_SHIFT = 13'b0000000000100,
        S_SQ    = 13'b0000000001000,
        S_SQADD = 13'b0000000010000,
        S_ROOT  = 13'b0000000100000,
        S_DSET  = 13'b0000001000000,
        S_DIV   = 13'b0000010000000,
        S_NFIN  = 13'b0000100000000,
        S_XMUL  = 13'b0001000000000,
        S_XSET  = 13'b0010000000000,
        S_NRND  = 13'b0100000000000,
        S_DONE  = 13'b1000000000000
    } state_t;

    typedef enum logic [1:0] {
        J_TAN,
        J_BIN,
        J_NRM
    } job_t;

    state_t             state_reg;
    job_t               job_reg;
    ffd_pkg::item_t     item_reg;
    ffd_pkg::vec_t      t_reg;
    ffd_pkg::vec_t      b_reg;
    ffd_pkg::vec_t      n_reg;
    logic [1:0]         status_reg;
    logic [63:0]        m_reg [3];
    logic [2:0]         neg_reg;
    logic signed [63:0] cx_reg [3];
    logic signed [31:0] q_reg [3];
    logic               zero_reg;
    logic [1:0]         comp_reg;
    logic [2:0]         step_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] pa_reg;
    logic [63:0]        sqp_reg;
    logic [63:0]        sum_reg;
    logic [63:0]        rem_reg;
    logic [63:0]        res_reg;
    logic [63:0]        rbit_reg;
    logic [BW-1:0]      bidx_reg;
    logic [QW-1:0]      quo_reg;

    function automatic logic signed [31:0] pick(ffd_pkg::vec_t v, logic [1:0] i);
        case (i)
            2'd0:    return v.x;
            2'd1:    return v.y;
            default: return v.z;
        endcase
    endfunction

    function automatic logic signed [31:0] round_sat(logic signed [63:0] c);
        logic [64:0] mag;
        logic [64:0] r;
        mag = c[63] ? 65'(-c) : 65'(c);
        r   = (mag + (65'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (c[63])
        begin
            if (r >= 65'h8000_0000)
            begin
                return 32'sh8000_0000;
            end
            return -32'(r);
        end
        if (r > 65'h7FFF_FFFF)
        begin
            return 32'sh7FFF_FFFF;
        end
        return 32'(r);
    endfunction

    ffd_pkg::vec_t      op_a;
    ffd_pkg::vec_t      op_b;
    logic [1:0]         xi;
    logic [1:0]         xj;
    logic [1:0]         xk;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] prod;
    logic [2:0]         prev;
    logic [63:0]        m_sel;
    logic [63:0]        root_try;
    logic [63:0]        trial;
    logic               hit;
    logic [QW-1:0]      quo_next;
    logic signed [31:0] quo_val;
    logic               big;
    ffd_pkg::vec_t      res_vec;

    always_comb
    begin
        op_a  = (job_reg == J_BIN) ? item_reg.v : b_reg;
        op_b  = (job_reg == J_BIN) ? item_reg.a : t_reg;
        xi    = step_reg[2:1];
        xj    = (xi == 2'd2) ? 2'd0 : xi + 2'd1;
        xk    = (xi == 2'd0) ? 2'd2 : xi - 2'd1;
        mul_a = step_reg[0] ? pick(op_a, xk) : pick(op_a, xj);
        mul_b = step_reg[0] ? pick(op_b, xj) : pick(op_b, xk);
        prod  = mul_a * mul_b;
        prev  = step_reg - 3'd1;
        m_sel = m_reg[comp_reg];
        root_try = res_reg + rbit_reg;
        trial    = res_reg << bidx_reg;
        hit      = (rem_reg >= trial);
        quo_next = quo_reg;
        quo_next[bidx_reg] = hit;
        quo_val  = 32'(quo_next);
        big      = (m_reg[0] > 64'h8000_0000) || (m_reg[1] > 64'h8000_0000)
                   || (m_reg[2] > 64'h8000_0000);
        res_vec  = '{x: q_reg[0], y: q_reg[1], z: q_reg[2]};
    end

    assign q_pop       = (state_reg == S_IDLE) && q_valid;
    assign frame_valid = (state_reg == S_DONE);
    assign frame = '{p: item_reg.p, t: t_reg, n: n_reg, b: b_reg, status: status_reg};

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_IDLE:
            begin
                item_reg <= q_data;
                neg_reg  <= {q_data.v.z[31], q_data.v.y[31], q_data.v.x[31]};
                m_reg[0] <= q_data.v.x[31] ? 64'(-33'(q_data.v.x)) : 64'(q_data.v.x);
                m_reg[1] <= q_data.v.y[31] ? 64'(-33'(q_data.v.y)) : 64'(q_data.v.y);
                m_reg[2] <= q_data.v.z[31] ? 64'(-33'(q_data.v.z)) : 64'(q_data.v.z);
            end
            S_NZERO:
            begin
                zero_reg <= ((m_reg[0] | m_reg[1] | m_reg[2]) == 64'd0);
                comp_reg <= 2'd0;
                sum_reg  <= 64'd0;
                q_reg[0] <= '0;
                q_reg[1] <= '0;
                q_reg[2] <= '0;
            end
            S_SHIFT:
            begin
                if (big)
                begin
                    m_reg[0] <= m_reg[0] >> 1;
                    m_reg[1] <= m_reg[1] >> 1;
                    m_reg[2] <= m_reg[2] >> 1;
                end
            end
            S_SQ:
            begin
                sqp_reg <= m_sel[31:0] * m_sel[31:0];
                if (comp_reg != 2'd0)
                begin
                    sum_reg <= sum_reg + sqp_reg;
                end
                comp_reg <= comp_reg + 2'd1;
            end
            S_SQADD:
            begin
                rem_reg  <= sum_reg + sqp_reg;
                res_reg  <= 64'd0;
                rbit_reg <= 64'd1 << 62;
                comp_reg <= 2'd0;
            end
            S_ROOT:
            begin
                if (rem_reg >= root_try)
                begin
                    rem_reg <= rem_reg - root_try;
                    res_reg <= (res_reg >> 1) + rbit_reg;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
                rbit_reg <= rbit_reg >> 2;
            end
            S_DSET:
            begin
                rem_reg  <= (m_sel << FRAC_BITS) + (res_reg >> 1);
                bidx_reg <= BW'(FRAC_BITS);
                quo_reg  <= '0;
            end
            S_DIV:
            begin
                if (hit)
                begin
                    rem_reg <= rem_reg - trial;
                end
                quo_reg <= quo_next;
                if (bidx_reg == '0)
                begin
                    q_reg[comp_reg] <= neg_reg[comp_reg] ? -quo_val : quo_val;
                    comp_reg <= comp_reg + 2'd1;
                end
                else
                begin
                    bidx_reg <= bidx_reg - BW'(1);
                end
            end
            S_NFIN:
            begin
                step_reg <= 3'd0;
                if (job_reg == J_TAN)
                begin
                    t_reg      <= res_vec;
                    status_reg <= zero_reg ? ffd_pkg::ST_NOTAN : ffd_pkg::ST_OK;
                end
                else
                begin
                    b_reg <= res_vec;
                    if (zero_reg)
                    begin
                        n_reg <= '0;
                        if (status_reg == ffd_pkg::ST_OK)
                        begin
                            status_reg <= ffd_pkg::ST_FLAT;
                        end
                    end
                end
            end
            S_XMUL:
            begin
                prod_reg <= prod;
                if (step_reg != 3'd0)
                begin
                    if (!prev[0])
                    begin
                        pa_reg <= prod_reg;
                    end
                    else
                    begin
                        cx_reg[prev[2:1]] <= pa_reg - prod_reg;
                    end
                end
                step_reg <= step_reg + 3'd1;
            end
            S_XSET:
            begin
                neg_reg  <= {cx_reg[2][63], cx_reg[1][63], cx_reg[0][63]};
                m_reg[0] <= cx_reg[0][63] ? 64'(-cx_reg[0]) : 64'(cx_reg[0]);
                m_reg[1] <= cx_reg[1][63] ? 64'(-cx_reg[1]) : 64'(cx_reg[1]);
                m_reg[2] <= cx_reg[2][63] ? 64'(-cx_reg[2]) : 64'(cx_reg[2]);
            end
            S_NRND:
            begin
                n_reg <= '{x: round_sat(cx_reg[0]), y: round_sat(cx_reg[1]),
                           z: round_sat(cx_reg[2])};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            job_reg   <= J_TAN;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        job_reg   <= J_TAN;
                        state_reg <= S_NZERO;
                    end
                end
                S_NZERO:
                begin
                    if ((m_reg[0] | m_reg[1] | m_reg[2]) == 64'd0)
                    begin
                        state_reg <= S_NFIN;
                    end
                    else
                    begin
                        state_reg <= S_SHIFT;
                    end
                end
                S_SHIFT:
                begin
                    if (!big)
                    begin
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    if (comp_reg == 2'd2)
                    begin
                        state_reg <= S_SQADD;
                    end
                end
                S_SQADD:
                begin
                    state_reg <= S_ROOT;
                end
                S_ROOT:
                begin
                    if (rbit_reg == 64'd1)
                    begin
                        state_reg <= S_DSET;
                    end
                end
                S_DSET:
                begin
                    state_reg <= S_DIV;
                end
                S_DIV:
                begin
                    if (bidx_reg == '0)
                    begin
                        state_reg <= (comp_reg == 2'd2) ? S_NFIN : S_DSET;
                    end
                end
                S_NFIN:
                begin
                    if (job_reg == J_TAN)
                    begin
                        job_reg   <= J_BIN;
                        state_reg <= S_XMUL;
                    end
                    else if (zero_reg)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        job_reg   <= J_NRM;
                        state_reg <= S_XMUL;
                    end
                end
                S_XMUL:
                begin
                    if (step_reg == 3'd6)
                    begin
                        state_reg <= (job_reg == J_BIN) ? S_XSET : S_NRND;
                    end
                end
                S_XSET:
                begin
                    state_reg <= S_NZERO;
                end
                S_NRND:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (frame_ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// File: rtl/ffd_emit.sv
// output stage: holds one finished frame and hands out its four vectors
module ffd_emit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               frame_valid,
    output logic               frame_ready,
    input  ffd_pkg::frame_t    frame,
    output logic               empty,
    input  logic               pop,
    output logic [1:0]         vector_kind,
    output logic signed [31:0] comp_x,
    output logic signed [31:0] comp_y,
    output logic signed [31:0] comp_z,
    output logic [1:0]         frame_status,
    output logic               is_last
);

    ffd_pkg::frame_t frame_reg;
    logic            busy_reg;
    logic [1:0]      kind_reg;
    ffd_pkg::vec_t   sel;

    always_comb
    begin
        case (kind_reg)
            ffd_pkg::KIND_POS: sel = frame_reg.p;
            ffd_pkg::KIND_TAN: sel = frame_reg.t;
            ffd_pkg::KIND_NRM: sel = frame_reg.n;
            default:           sel = frame_reg.b;
        endcase
    end

    assign frame_ready  = !busy_reg;
    assign empty        = !busy_reg;
    assign vector_kind  = kind_reg;
    assign comp_x       = sel.x;
    assign comp_y       = sel.y;
    assign comp_z       = sel.z;
    assign frame_status = frame_reg.status;
    assign is_last      = (kind_reg == ffd_pkg::KIND_BIN);

    always_ff @(posedge clk)
    begin
        if (frame_valid && !busy_reg)
        begin
            frame_reg <= frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            kind_reg <= ffd_pkg::KIND_POS;
        end
        else if (!busy_reg)
        begin
            busy_reg <= frame_valid;
            kind_reg <= ffd_pkg::KIND_POS;
        end
        else if (pop)
        begin
            if (is_last)
            begin
                busy_reg <= 1'b0;
            end
            kind_reg <= kind_reg + 2'd1;
        end
    end

endmodule

// File: rtl/ffd_checker.sv
// port-level checks of the result sequence
module ffd_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               empty,
    input logic               pop,
    input logic [1:0]         vector_kind,
    input logic signed [31:0] comp_x,
    input logic signed [31:0] comp_y,
    input logic signed [31:0] comp_z,
    input logic [1:0]         frame_status,
    input logic               is_last
);

    // last flag marks the binormal only
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (is_last == (vector_kind == ffd_pkg::KIND_BIN)))
        else $error("is_last out of step with vector_kind");

    // the four vectors of a frame follow without a gap
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !is_last) |=>
            (!empty && vector_kind == 2'($past(vector_kind) + 2'd1)))
        else $error("frame vectors out of order");

    // status is the same over one frame
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !is_last) |=> (frame_status == $past(frame_status)))
        else $error("frame_status changed within a frame");

    // no status code beyond zero tangent
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (frame_status != 2'd3))
        else $error("bad frame_status");

    // zero tangent gives zero tangent, normal and binormal
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && frame_status == ffd_pkg::ST_NOTAN && vector_kind != ffd_pkg::KIND_POS)
            |-> (comp_x == 32'sd0 && comp_y == 32'sd0 && comp_z == 32'sd0))
        else $error("nonzero vector with zero tangent");

endmodule

bind frenet_frame_from_derivatives ffd_checker u_ffd_checker (.*);

// File: test/tb_frenet_frame_from_derivatives.sv
// testbench for the frenet frame block: directed table and random transactions against a predictor
module tb_frenet_frame_from_derivatives;

    localparam int FRAC = 16;
    localparam int N_RANDOM = 450;
    localparam longint CYCLE_LIMIT = 1200000;

    typedef struct {
        logic [1:0]  kind;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [1:0]  status;
        logic        last;
    } vec_result_t;

    typedef struct {
        logic [31:0] f[9];
        logic        known;
        logic [1:0]  known_status;
    } stim_row_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_wdata;
    logic        push;
    logic        full;
    logic signed [31:0] pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z;
    logic        empty;
    logic        pop;
    logic [1:0]  vector_kind;
    logic signed [31:0] comp_x, comp_y, comp_z;
    logic [1:0]  frame_status;
    logic        is_last;

    vec_result_t expected_q[$];
    logic [1:0]  dim_mirror;
    int          n_errors;
    longint      n_cycles;
    logic        hold_pop;
    logic        drain_req;

    frenet_frame_from_derivatives #(.FRAC_BITS(FRAC)) u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .push(push), .full(full),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .vel_x(vel_x), .vel_y(vel_y), .vel_z(vel_z),
        .acc_x(acc_x), .acc_y(acc_y), .acc_z(acc_z),
        .empty(empty), .pop(pop), .vector_kind(vector_kind),
        .comp_x(comp_x), .comp_y(comp_y), .comp_z(comp_z),
        .frame_status(frame_status), .is_last(is_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [31:0] sat32(bit neg, logic [63:0] mag);
        if (neg)
            return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // sign/magnitude cross product of a and b
    task automatic cross_sm(input longint a[3], input longint b[3],
                            output bit neg[3], output logic [63:0] mag[3]);
        longint p1, p2;
        for (int i = 0; i < 3; i++)
        begin
            p1 = a[(i + 1) % 3] * b[(i + 2) % 3];
            p2 = a[(i + 2) % 3] * b[(i + 1) % 3];
            neg[i] = p1 < p2;
            mag[i] = neg[i] ? 64'(p2) - 64'(p1) : 64'(p1) - 64'(p2);
        end
    endtask

    function automatic bit unit_vector(bit neg[3], logic [63:0] mag[3], output longint q[3]);
        logic [63:0] m[3];
        logic [63:0] sum, len, r;
        m = mag;
        q[0] = 0; q[1] = 0; q[2] = 0;
        if ((m[0] | m[1] | m[2]) == 0)
            return 0;
        while (m[0] > 64'h8000_0000 || m[1] > 64'h8000_0000 || m[2] > 64'h8000_0000)
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++)
        begin
            r = ((m[i] << FRAC) + (len >> 1)) / len;
            q[i] = longint'(signed'(sat32(neg[i], r)));
        end
        return 1;
    endfunction

    task automatic predict_frame(input logic [31:0] f[9]);
        longint d[9], p[3], t[3], n[3], b[3], va[3], ac[3];
        bit ng[3];
        logic [63:0] mg[3];
        logic [1:0] st;
        longint vecs[4][3];
        vec_result_t r;
        st = ffd_pkg::ST_OK;
        for (int i = 0; i < 9; i++) d[i] = longint'(signed'(f[i]));
        if (dim_mirror == 2'd1)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d[3 * i + 1] = longint'(signed'(f[3 * i]));
                d[3 * i] = 0;
                d[3 * i + 2] = 0;
            end
            d[3] = longint'(1) << FRAC;
        end
        else if (dim_mirror == 2'd2)
        begin
            d[2] = 0; d[5] = 0; d[8] = 0;
        end
        for (int i = 0; i < 3; i++)
        begin
            p[i] = d[i];
            va[i] = d[3 + i];
            ac[i] = d[6 + i];
            ng[i] = va[i] < 0;
            mg[i] = va[i] < 0 ? -64'(va[i]) : 64'(va[i]);
        end
        if (!unit_vector(ng, mg, t)) st = ffd_pkg::ST_NOTAN;
        cross_sm(va, ac, ng, mg);
        if (!unit_vector(ng, mg, b))
        begin
            n[0] = 0; n[1] = 0; n[2] = 0;
            if (st == ffd_pkg::ST_OK) st = ffd_pkg::ST_FLAT;
        end
        else
        begin
            cross_sm(b, t, ng, mg);
            for (int i = 0; i < 3; i++)
                n[i] = longint'(signed'(sat32(ng[i], (mg[i] + (64'd1 << (FRAC - 1))) >> FRAC)));
        end
        vecs[0] = p; vecs[1] = t; vecs[2] = n; vecs[3] = b;
        for (int k = 0; k < 4; k++)
        begin
            r.kind = 2'(k);
            r.x = 32'(vecs[k][0]);
            r.y = 32'(vecs[k][1]);
            r.z = 32'(vecs[k][2]);
            r.status = st;
            r.last = (k == 3);
            expected_q.push_back(r);
        end
    endtask

    task automatic send_item(input logic [31:0] f[9]);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push <= 1'b1;
        {pos_x, pos_y, pos_z} <= {f[0], f[1], f[2]};
        {vel_x, vel_y, vel_z} <= {f[3], f[4], f[5]};
        {acc_x, acc_y, acc_z} <= {f[6], f[7], f[8]};
        @(posedge clk);
        while (full) @(posedge clk);
        predict_frame(f);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic set_dimension(input logic [1:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        dim_mirror = value;
    endtask

    function automatic logic [31:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 32'($urandom_range(0, 4)) - 32'd2;
            1: return 32'h7FFF_FFFF - 32'($urandom_range(0, 2));
            2: return 32'h8000_0000 + 32'($urandom_range(0, 2));
            3: return 32'(signed'(16'($urandom())));
            default: return $urandom();
        endcase
    endfunction

    // result side
    initial
    begin
        vec_result_t e;
        int wait_left;
        pop = 1'b0;
        wait_left = $urandom_range(0, 3);
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected transaction kind %0d", $time, vector_kind);
                    n_errors++;
                end
                else
                begin
                    e = expected_q.pop_front();
                    if ({vector_kind, comp_x, comp_y, comp_z, frame_status, is_last} !==
                        {e.kind, e.x, e.y, e.z, e.status, e.last})
                    begin
                        $display({"%0t: expected kind %0d (%h %h %h) st %0d last %0d,",
                                  " got kind %0d (%h %h %h) st %0d last %0d"},
                                 $time, e.kind, e.x, e.y, e.z, e.status, e.last,
                                 vector_kind, comp_x, comp_y, comp_z, frame_status, is_last);
                        n_errors++;
                    end
                end
                wait_left = $urandom_range(0, 3);
            end
            if (hold_pop)
                pop <= 1'b0;
            else if (wait_left > 0)
            begin
                pop <= 1'b0;
                wait_left--;
            end
            else
                pop <= 1'b1;
        end
    end

    // long receiver hold-off, counted here
    initial
    begin
        hold_pop = 1'b0;
        wait (drain_req);
        hold_pop = 1'b1;
        repeat (3000) @(posedge clk);
        hold_pop = 1'b0;
    end

    initial
    begin
        n_cycles = 0;
        forever
        begin
            @(posedge clk);
            n_cycles++;
            if (n_cycles > CYCLE_LIMIT)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        stim_row_t rows[$];
        stim_row_t row;
        logic [31:0] f[9];
        logic [1:0] dims[4];
        n_errors = 0;
        drain_req = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 2'd3;
        push = 1'b0;
        {pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, acc_x, acc_y, acc_z} = '0;
        dim_mirror = 2'd3;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table: zero tangent, zero curvature, extremes, generic frames
        row.known = 1'b1;
        row.known_status = ffd_pkg::ST_NOTAN;
        row.f = '{32'h7FFF_FFFF, 32'h8000_0000, 32'd5, 0, 0, 0, 32'h10000, 0, 0};
        rows.push_back(row);
        row.known_status = ffd_pkg::ST_FLAT;
        row.f = '{1, 2, 3, 32'h10000, 0, 0, 32'h20000, 0, 0};
        rows.push_back(row);
        row.f = '{0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF};
        row.known = 1'b0;
        rows.push_back(row);
        row.f = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h10000, 0, 0, 0, 32'h10000, 0};
        rows.push_back(row);
        row.f = '{0, 0, 0, 32'h7FFF_FFFF, 1, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1};
        rows.push_back(row);
        row.f = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        rows.push_back(row);
        row.f = '{5, 6, 7, 32'hFFFF_0000, 32'h30000, 32'h8000, 32'h1234, 32'hFFFE_0000, 32'h50000};
        rows.push_back(row);

        dims = '{2'd3, 2'd2, 2'd1, 2'd0};
        foreach (dims[di])
        begin
            set_dimension(dims[di]);
            foreach (rows[ri])
            begin
                f = rows[ri].f;
                send_item(f);
                if (rows[ri].known && dims[di] != 2'd1 &&
                    expected_q[expected_q.size() - 1].status !== rows[ri].known_status)
                begin
                    $display("%0t: expected status %0d, predictor gave %0d", $time,
                             rows[ri].known_status, expected_q[expected_q.size() - 1].status);
                    n_errors++;
                end
            end
        end

        // receiver stalls long while items keep coming
        drain_req = 1'b1;
        for (int i = 0; i < 8; i++)
        begin
            foreach (f[k]) f[k] = rand_field();
            send_item(f);
        end

        for (int i = 0; i < N_RANDOM; i++)
        begin
            if (i % 90 == 45)
                set_dimension(2'($urandom_range(0, 3)));
            if (i == 200)
                wait_drained();
            foreach (f[k]) f[k] = rand_field();
            if ($urandom_range(0, 9) == 0)
            begin
                f[3] = 0; f[4] = 0; f[5] = 0;
            end
            else if ($urandom_range(0, 9) == 0)
            begin
                f[6] = f[3]; f[7] = f[4]; f[8] = f[5];
            end
            send_item(f);
        end

        wait_drained();
        if (n_errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
